// File: hw/rtl/svwi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svwi_pkg
// Shared constants and types for the viewport wall crossing pipeline.
// ----------------------------------------------------------------------------
package svwi_pkg;

	localparam int COORD_BITS_DEF = 14;
	localparam int CFG_BITS       = 12;
	localparam int CFG_IDX_BITS   = 2;
	localparam int QUOT_BITS      = 12;
	localparam int NUM_WALLS      = 4;

	localparam logic [CFG_BITS-1:0] VIEW_WIDTH_RST  = 12'd1280;
	localparam logic [CFG_BITS-1:0] VIEW_HEIGHT_RST = 12'd820;
	localparam logic [CFG_BITS-1:0] VIEW_TOP_RST    = 12'd100;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_VIEW_WIDTH  = 2'd0,
		CFG_VIEW_HEIGHT = 2'd1,
		CFG_VIEW_TOP    = 2'd2
	} cfg_idx_t;

	typedef enum logic [1:0] {
		WALL_WEST  = 2'd0,
		WALL_NORTH = 2'd1,
		WALL_EAST  = 2'd2,
		WALL_SOUTH = 2'd3
	} wall_t;

endpackage

// File: hw/rtl/svwi_wall_calc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svwi_wall_calc
// Three-stage front end of one wall test: differences, products, then the
// parameter range check and the numerator and divisor for the crossing.
// The wall is taken as vertical at u = pos from v = lo to v = hi.
// ----------------------------------------------------------------------------
module svwi_wall_calc #(
	parameter int CB = svwi_pkg::COORD_BITS_DEF
) (
	input  logic                              clk,
	input  logic [2:0]                        en,
	input  logic signed [CB-1:0]              u0,
	input  logic signed [CB-1:0]              v0,
	input  logic signed [CB-1:0]              u1,
	input  logic signed [CB-1:0]              v1,
	input  logic [svwi_pkg::CFG_BITS-1:0]     pos,
	input  logic [svwi_pkg::CFG_BITS-1:0]     lo,
	input  logic [svwi_pkg::CFG_BITS-1:0]     hi,
	output logic                              ok_s3,
	output logic [CB+svwi_pkg::QUOT_BITS-1:0] n2_s3,
	output logic [CB:0]                       d_s3
);

	localparam int BW  = (CB > 13) ? CB : 13;
	localparam int DUW = CB + 1;
	localparam int RW  = BW + 1;
	localparam int EW  = svwi_pkg::CFG_BITS + 1;
	localparam int PMW = DUW + RW;
	localparam int SW  = PMW + 2;
	localparam int NW  = CB + svwi_pkg::QUOT_BITS;

	logic signed [DUW-1:0] du_s1, dv_s1, du_s2;
	logic signed [RW-1:0]  ru_s1, rv_s1;
	logic signed [EW-1:0]  e_s1;

	logic signed [PMW-1:0]    pa_s2, pb_s2;
	logic signed [DUW+EW-1:0] den_s2, pl_s2;
	logic signed [EW+RW:0]    tn_s2;

	logic signed [SW-1:0] sn, den, tn, m, n2;
	logic                 sn_ok, tn_ok, ok;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			du_s1 <= DUW'(u1) - DUW'(u0);
			dv_s1 <= DUW'(v1) - DUW'(v0);
			ru_s1 <= RW'(u0) - $signed(RW'({1'b0, pos}));
			rv_s1 <= RW'(v0) - $signed(RW'({1'b0, lo}));
			e_s1  <= $signed({1'b0, hi}) - $signed({1'b0, lo});
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			pa_s2  <= du_s1 * rv_s1;
			pb_s2  <= dv_s1 * ru_s1;
			den_s2 <= du_s1 * e_s1;
			tn_s2  <= -(e_s1 * ru_s1);
			pl_s2  <= du_s1 * $signed({1'b0, lo});
			du_s2  <= du_s1;
		end
	end

	always_comb begin
		sn  = SW'(pa_s2) - SW'(pb_s2);
		den = SW'(den_s2);
		tn  = SW'(tn_s2);
		if (!den[SW-1]) begin
			sn_ok = !sn[SW-1] && (sn <= den);
			tn_ok = !tn[SW-1] && (tn <= den);
		end else begin
			sn_ok = (sn <= 0) && (sn >= den);
			tn_ok = (tn <= 0) && (tn >= den);
		end
		ok = (den != '0) && sn_ok && tn_ok;
		m  = SW'(pl_s2) + sn;
		n2 = du_s2[DUW-1] ? -m : m;
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			ok_s3 <= ok;
			n2_s3 <= n2[NW-1:0];
			d_s3  <= du_s2[DUW-1] ? $unsigned(-du_s2) : $unsigned(du_s2);
		end
	end

endmodule

// File: hw/rtl/svwi_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svwi_div
// Restoring divider, one quotient bit per pipeline stage, most significant
// bit first. The quotient is known to fit QW bits when ok is set.
// ----------------------------------------------------------------------------
module svwi_div #(
	parameter int NW = 26,
	parameter int DW = 15,
	parameter int QW = svwi_pkg::QUOT_BITS
) (
	input  logic          clk,
	input  logic [QW-1:0] en,
	input  logic [NW-1:0] n_in,
	input  logic [DW-1:0] d_in,
	input  logic          ok_in,
	output logic [QW-1:0] q_out,
	output logic          ok_out
);

	localparam int MW = (NW > DW + QW) ? NW : DW + QW;

	logic [NW-1:0] rem_s [QW];
	logic [DW-1:0] d_s   [QW];
	logic [QW-1:0] q_s   [QW];
	logic          ok_s  [QW];

	for (genvar i = 0; i < QW; i++) begin : g_step
		logic [NW-1:0] rem_p, rem_n;
		logic [DW-1:0] d_p;
		logic [QW-1:0] q_p, q_n;
		logic          ok_p, ge;
		logic [MW-1:0] dsh;

		if (i == 0) begin : g_first
			assign rem_p = n_in;
			assign d_p   = d_in;
			assign q_p   = '0;
			assign ok_p  = ok_in;
		end else begin : g_next
			assign rem_p = rem_s[i-1];
			assign d_p   = d_s[i-1];
			assign q_p   = q_s[i-1];
			assign ok_p  = ok_s[i-1];
		end

		always_comb begin
			dsh   = MW'(d_p) << (QW - 1 - i);
			ge    = MW'(rem_p) >= dsh;
			rem_n = ge ? NW'(MW'(rem_p) - dsh) : rem_p;
			q_n   = q_p;
			q_n[QW-1-i] = ge;
		end

		always_ff @(posedge clk) begin
			if (en[i]) begin
				rem_s[i] <= rem_n;
				d_s[i]   <= d_p;
				q_s[i]   <= q_n;
				ok_s[i]  <= ok_p;
			end
		end
	end

	assign q_out  = q_s[QW-1];
	assign ok_out = ok_s[QW-1];

endmodule

// File: hw/rtl/segment_viewport_wall_intersect_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_viewport_wall_intersect_top
// Finds the first accepted crossing of a segment with the viewport walls,
// tested west, north, east, south, all four walls in parallel lanes.
// ----------------------------------------------------------------------------
// Pipeline: 3 arithmetic stages, 12 divider stages, one output register.
// Throughput: one beat per cycle unless output back-pressure stalls it;
// each stage advances when empty or when the stage after it advances,
// so bubbles collapse under output back-pressure.
// Reset: pipeline valid bits cleared, view registers to 1280, 820, 100.
module segment_viewport_wall_intersect_top #(
	parameter int COORD_BITS = svwi_pkg::COORD_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// start_x, start_y, far_x, far_y
	input  logic [((4*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// cross_x, cross_y
	output logic [((2*COORD_BITS+7)/8)*8-1:0] m_axis_tdata,
	// hit, wall
	output logic [2:0] m_axis_tuser,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [svwi_pkg::CFG_IDX_BITS-1:0] cfg_addr,
	input  logic [svwi_pkg::CFG_BITS-1:0] cfg_wdata
);

	localparam int CB     = COORD_BITS;
	localparam int IN_W   = 4 * CB;
	localparam int OUT_TW = ((2 * CB + 7) / 8) * 8;
	localparam int QW     = svwi_pkg::QUOT_BITS;
	localparam int NW     = CB + QW;
	localparam int DW     = CB + 1;
	localparam int NST    = 3 + QW + 1;
	localparam int BW     = (CB > 13) ? CB : 13;
	localparam int CMPW   = BW + 1;
	localparam int NWL    = svwi_pkg::NUM_WALLS;
	localparam int CFW    = svwi_pkg::CFG_BITS;

	logic [CFW-1:0] view_width_q, view_height_q, view_top_q;

	logic [NST-1:0] vld_q;
	logic [NST-1:0] en;
	logic [IN_W-1:0] coord_s [NST-1];

	logic signed [CB-1:0] u0 [NWL];
	logic signed [CB-1:0] v0 [NWL];
	logic signed [CB-1:0] u1 [NWL];
	logic signed [CB-1:0] v1 [NWL];
	logic [CFW-1:0] pos [NWL];
	logic [CFW-1:0] lo  [NWL];
	logic [CFW-1:0] hi  [NWL];
	logic           swap [NWL];

	logic           ok_s3 [NWL];
	logic [NW-1:0]  n2_s3 [NWL];
	logic [DW-1:0]  d_s3  [NWL];
	logic [QW-1:0]  q_f   [NWL];
	logic           ok_f  [NWL];

	logic signed [CB-1:0] in_p0x, in_p0y, in_p1x, in_p1y;
	logic signed [CB-1:0] p0x, p0y, p1x, p1y;
	logic [CFW-1:0] cx [NWL];
	logic [CFW-1:0] cy [NWL];
	logic [NWL-1:0] acc;

	logic                 hit_d;
	svwi_pkg::wall_t      wall_d;
	logic [CFW-1:0]       cx_d, cy_d;
	logic                 hit_s16;
	svwi_pkg::wall_t      wall_s16;
	logic [CB-1:0]        cx_s16, cy_s16;

	// configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			view_width_q  <= svwi_pkg::VIEW_WIDTH_RST;
			view_height_q <= svwi_pkg::VIEW_HEIGHT_RST;
			view_top_q    <= svwi_pkg::VIEW_TOP_RST;
		end else if (cfg_valid) begin
			unique case (cfg_addr)
				svwi_pkg::CFG_VIEW_WIDTH:  view_width_q  <= cfg_wdata;
				svwi_pkg::CFG_VIEW_HEIGHT: view_height_q <= cfg_wdata;
				svwi_pkg::CFG_VIEW_TOP:    view_top_q    <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// stage enables and valid bits
	assign en[NST-1] = ~vld_q[NST-1] | m_axis_tready;
	for (genvar k = 0; k < NST - 1; k++) begin : g_en
		assign en[k] = ~vld_q[k] | en[k+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) vld_q[0] <= s_axis_tvalid;
			for (int k = 1; k < NST; k++) begin
				if (en[k]) vld_q[k] <= vld_q[k-1];
			end
		end
	end

	assign s_axis_tready = en[0];
	assign m_axis_tvalid = vld_q[NST-1];

	// endpoint coordinates travel alongside the arithmetic
	always_ff @(posedge clk) begin
		if (en[0]) coord_s[0] <= s_axis_tdata[IN_W-1:0];
		for (int k = 1; k < NST - 1; k++) begin
			if (en[k]) coord_s[k] <= coord_s[k-1];
		end
	end

	assign in_p0x = s_axis_tdata[CB-1:0];
	assign in_p0y = s_axis_tdata[2*CB-1:CB];
	assign in_p1x = s_axis_tdata[3*CB-1:2*CB];
	assign in_p1y = s_axis_tdata[4*CB-1:3*CB];

	// horizontal walls are tested with x and y swapped
	always_comb begin
		pos[svwi_pkg::WALL_WEST]  = '0;
		lo[svwi_pkg::WALL_WEST]   = view_top_q;
		hi[svwi_pkg::WALL_WEST]   = view_height_q;
		swap[svwi_pkg::WALL_WEST] = 1'b0;
		pos[svwi_pkg::WALL_NORTH]  = view_top_q;
		lo[svwi_pkg::WALL_NORTH]   = '0;
		hi[svwi_pkg::WALL_NORTH]   = view_width_q;
		swap[svwi_pkg::WALL_NORTH] = 1'b1;
		pos[svwi_pkg::WALL_EAST]  = view_width_q;
		lo[svwi_pkg::WALL_EAST]   = view_top_q;
		hi[svwi_pkg::WALL_EAST]   = view_height_q;
		swap[svwi_pkg::WALL_EAST] = 1'b0;
		pos[svwi_pkg::WALL_SOUTH]  = view_height_q;
		lo[svwi_pkg::WALL_SOUTH]   = '0;
		hi[svwi_pkg::WALL_SOUTH]   = view_width_q;
		swap[svwi_pkg::WALL_SOUTH] = 1'b1;
		for (int w = 0; w < NWL; w++) begin
			u0[w] = swap[w] ? in_p0y : in_p0x;
			v0[w] = swap[w] ? in_p0x : in_p0y;
			u1[w] = swap[w] ? in_p1y : in_p1x;
			v1[w] = swap[w] ? in_p1x : in_p1y;
		end
	end

	for (genvar w = 0; w < NWL; w++) begin : g_wall
		svwi_wall_calc #(
			.CB(CB)
		) u_calc (
			.clk   (clk),
			.en    (en[2:0]),
			.u0    (u0[w]),
			.v0    (v0[w]),
			.u1    (u1[w]),
			.v1    (v1[w]),
			.pos   (pos[w]),
			.lo    (lo[w]),
			.hi    (hi[w]),
			.ok_s3 (ok_s3[w]),
			.n2_s3 (n2_s3[w]),
			.d_s3  (d_s3[w])
		);

		svwi_div #(
			.NW(NW),
			.DW(DW),
			.QW(QW)
		) u_div (
			.clk    (clk),
			.en     (en[QW+2:3]),
			.n_in   (n2_s3[w]),
			.d_in   (d_s3[w]),
			.ok_in  (ok_s3[w]),
			.q_out  (q_f[w]),
			.ok_out (ok_f[w])
		);
	end

	// endpoint rejection and wall priority
	assign p0x = coord_s[NST-2][CB-1:0];
	assign p0y = coord_s[NST-2][2*CB-1:CB];
	assign p1x = coord_s[NST-2][3*CB-1:2*CB];
	assign p1y = coord_s[NST-2][4*CB-1:3*CB];

	always_comb begin
		for (int w = 0; w < NWL; w++) begin
			cx[w]  = swap[w] ? q_f[w] : pos[w];
			cy[w]  = swap[w] ? pos[w] : q_f[w];
			acc[w] = ok_f[w]
				&& !(($signed(CMPW'({1'b0, cx[w]})) == CMPW'(p0x))
					&& ($signed(CMPW'({1'b0, cy[w]})) == CMPW'(p0y)))
				&& !(($signed(CMPW'({1'b0, cx[w]})) == CMPW'(p1x))
					&& ($signed(CMPW'({1'b0, cy[w]})) == CMPW'(p1y)))
				&& (q_f[w] != lo[w]) && (q_f[w] != hi[w]);
		end
		hit_d  = 1'b1;
		wall_d = svwi_pkg::WALL_WEST;
		cx_d   = cx[svwi_pkg::WALL_WEST];
		cy_d   = cy[svwi_pkg::WALL_WEST];
		if (acc[svwi_pkg::WALL_WEST]) begin
			wall_d = svwi_pkg::WALL_WEST;
		end else if (acc[svwi_pkg::WALL_NORTH]) begin
			wall_d = svwi_pkg::WALL_NORTH;
			cx_d   = cx[svwi_pkg::WALL_NORTH];
			cy_d   = cy[svwi_pkg::WALL_NORTH];
		end else if (acc[svwi_pkg::WALL_EAST]) begin
			wall_d = svwi_pkg::WALL_EAST;
			cx_d   = cx[svwi_pkg::WALL_EAST];
			cy_d   = cy[svwi_pkg::WALL_EAST];
		end else if (acc[svwi_pkg::WALL_SOUTH]) begin
			wall_d = svwi_pkg::WALL_SOUTH;
			cx_d   = cx[svwi_pkg::WALL_SOUTH];
			cy_d   = cy[svwi_pkg::WALL_SOUTH];
		end else begin
			hit_d = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en[NST-1]) begin
			hit_s16  <= hit_d;
			wall_s16 <= wall_d;
			cx_s16   <= hit_d ? CB'(cx_d) : '1;
			cy_s16   <= hit_d ? CB'(cy_d) : '1;
		end
	end

	assign m_axis_tdata = OUT_TW'({cy_s16, cx_s16});
	assign m_axis_tuser = {wall_s16, hit_s16};

endmodule

// File: tb/sv/segment_viewport_wall_intersect_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_viewport_wall_intersect_checker
// Watches the segment, result and register channels of the wall crossing
// block, works out the expected crossing for every accepted segment and
// compares each result beat field by field in order.
// ----------------------------------------------------------------------------
module segment_viewport_wall_intersect_checker #(
	parameter int COORD_BITS = 14
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	input  logic s_axis_tready,
	input  logic [((4*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
	input  logic m_axis_tvalid,
	input  logic m_axis_tready,
	input  logic [((2*COORD_BITS+7)/8)*8-1:0] m_axis_tdata,
	input  logic [2:0] m_axis_tuser,
	input  logic cfg_valid,
	input  logic cfg_ready,
	input  logic [svwi_pkg::CFG_IDX_BITS-1:0] cfg_addr,
	input  logic [svwi_pkg::CFG_BITS-1:0] cfg_wdata,
	output int   fail_count,
	output int   pending
);

	typedef struct packed {
		logic                  hit;
		svwi_pkg::wall_t       wall;
		logic [COORD_BITS-1:0] x;
		logic [COORD_BITS-1:0] y;
	} crossing_t;

	crossing_t crossing_q[$];
	logic [svwi_pkg::CFG_BITS-1:0] east_x, south_y, north_y;

	function automatic logic signed [63:0] coord(input int idx);
		logic [COORD_BITS-1:0] f;
		f = s_axis_tdata[idx*COORD_BITS +: COORD_BITS];
		return $signed(f);
	endfunction

	function automatic bit wall_cross(input longint px0, input longint py0,
			input longint px1, input longint py1, input longint ax,
			input longint ay, input longint bx, input longint by,
			output longint ox, output longint oy);
		longint dx, dy, ex, ey, rx, ry, den, sn, tn;
		dx = px1 - px0; dy = py1 - py0;
		ex = bx - ax; ey = by - ay;
		rx = px0 - ax; ry = py0 - ay;
		den = dx * ey - ex * dy;
		sn = dx * ry - dy * rx;
		tn = ex * ry - ey * rx;
		ox = 0; oy = 0;
		if (den == 0)
			return 0;
		if (den < 0) begin
			den = -den; sn = -sn; tn = -tn;
		end
		if (sn < 0 || sn > den || tn < 0 || tn > den)
			return 0;
		ox = (ax * den + sn * ex) / den;
		oy = (ay * den + sn * ey) / den;
		if ((ox == px0 && oy == py0) || (ox == px1 && oy == py1) ||
				(ox == ax && oy == ay) || (ox == bx && oy == by))
			return 0;
		return 1;
	endfunction

	function automatic crossing_t predict_crossing();
		crossing_t r;
		longint sx, sy, fx, fy, w, h, t, ox, oy;
		longint ax[4], ay[4], bx[4], by[4];
		sx = coord(0); sy = coord(1); fx = coord(2); fy = coord(3);
		w = east_x; h = south_y; t = north_y;
		ax = '{0, 0, w, 0}; ay = '{t, t, t, h};
		bx = '{0, w, w, w}; by = '{h, t, h, h};
		r.hit = 0; r.wall = svwi_pkg::WALL_WEST; r.x = '1; r.y = '1;
		for (int i = 0; i < svwi_pkg::NUM_WALLS; i++) begin
			if (wall_cross(sx, sy, fx, fy, ax[i], ay[i], bx[i], by[i], ox, oy)) begin
				r.hit = 1;
				r.wall = svwi_pkg::wall_t'(i);
				r.x = ox[COORD_BITS-1:0];
				r.y = oy[COORD_BITS-1:0];
				return r;
			end
		end
		return r;
	endfunction

	assign pending = crossing_q.size();

	always @(posedge clk or negedge arst_n) begin
		crossing_t got, want;
		if (!arst_n) begin
			east_x <= svwi_pkg::VIEW_WIDTH_RST;
			south_y <= svwi_pkg::VIEW_HEIGHT_RST;
			north_y <= svwi_pkg::VIEW_TOP_RST;
			fail_count <= 0;
			crossing_q.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (svwi_pkg::cfg_idx_t'(cfg_addr))
					svwi_pkg::CFG_VIEW_WIDTH: east_x <= cfg_wdata;
					svwi_pkg::CFG_VIEW_HEIGHT: south_y <= cfg_wdata;
					svwi_pkg::CFG_VIEW_TOP: north_y <= cfg_wdata;
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready)
				crossing_q.insert(crossing_q.size(), predict_crossing());
			if (m_axis_tvalid && m_axis_tready) begin
				got.hit = m_axis_tuser[0];
				got.wall = svwi_pkg::wall_t'(m_axis_tuser[2:1]);
				got.x = m_axis_tdata[0 +: COORD_BITS];
				got.y = m_axis_tdata[COORD_BITS +: COORD_BITS];
				if (crossing_q.size() == 0) begin
					$display("%0t: unexpected beat got %p", $time, got);
					fail_count <= fail_count + 1;
				end else begin
					want = crossing_q.pop_front();
					if (got !== want) begin
						$display("%0t: mismatch expected %p actual %p", $time, want, got);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end
endmodule

// File: tb/sv/segment_viewport_wall_intersect_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_viewport_wall_intersect_top_tb
// Drives segments aimed at, along and around the viewport walls through
// several register settings and idling and stall phases; the checker does the scoring.
// ----------------------------------------------------------------------------
module segment_viewport_wall_intersect_top_tb;

	localparam int CB = svwi_pkg::COORD_BITS_DEF;
	localparam int CFW = svwi_pkg::CFG_BITS;
	localparam int IN_TW = ((4*CB+7)/8)*8;
	localparam int LATENCY = 16;
	localparam int WATCHDOG = 20000;

	logic clk = 0, arst_n = 0;
	logic s_axis_tvalid = 0, s_axis_tready;
	logic [IN_TW-1:0] s_axis_tdata = '0;
	logic m_axis_tvalid, m_axis_tready = 0;
	logic [((2*CB+7)/8)*8-1:0] m_axis_tdata;
	logic [2:0] m_axis_tuser;
	logic cfg_valid = 0, cfg_ready;
	logic [svwi_pkg::CFG_IDX_BITS-1:0] cfg_addr = '0;
	logic [CFW-1:0] cfg_wdata = '0;
	int fail_count, pending;
	int send_idle = 0, recv_stall = 0;
	bit hold_off = 0;
	int quiet = 0;
	logic [CFW-1:0] vw = svwi_pkg::VIEW_WIDTH_RST, vh = svwi_pkg::VIEW_HEIGHT_RST;
	logic [CFW-1:0] vt = svwi_pkg::VIEW_TOP_RST;

	segment_viewport_wall_intersect_top #(.COORD_BITS(CB)) dut (.*);
	segment_viewport_wall_intersect_checker #(.COORD_BITS(CB)) chk (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	always @(negedge clk)
		m_axis_tready <= !hold_off && ($urandom_range(99) >= recv_stall);

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet > WATCHDOG) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	task automatic write_reg(input svwi_pkg::cfg_idx_t idx, input logic [CFW-1:0] v);
		@(negedge clk);
		cfg_valid <= 1; cfg_addr <= idx; cfg_wdata <= v;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 0;
	endtask

	task automatic release_bus();
		@(negedge clk);
		s_axis_tvalid <= 0;
	endtask

	task automatic drain();
		release_bus();
		while (pending != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic set_view(input logic [CFW-1:0] w, h, t);
		drain();
		vw = w; vh = h; vt = t;
		write_reg(svwi_pkg::CFG_VIEW_WIDTH, w);
		write_reg(svwi_pkg::CFG_VIEW_HEIGHT, h);
		write_reg(svwi_pkg::CFG_VIEW_TOP, t);
	endtask

	task automatic send(input logic signed [CB-1:0] sx, sy, fx, fy);
		@(negedge clk);
		while ($urandom_range(99) < send_idle) begin
			s_axis_tvalid <= 0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tdata <= IN_TW'({fy, fx, sy, sx});
		do @(posedge clk); while (!s_axis_tready);
	endtask

	function automatic logic signed [CB-1:0] near_wall(input int c);
		int v;
		case ($urandom_range(3))
			0: v = c + int'($urandom_range(8)) - 4;
			1: v = int'($urandom_range(2 * c + 40)) - 20;
			2: v = c;
			default: v = int'($urandom);
		endcase
		return CB'(v);
	endfunction

	task automatic random_segments(input int n);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(9) == 0)
				send(CB'($urandom), CB'($urandom), CB'($urandom), CB'($urandom));
			else
				send(near_wall($urandom_range(1) ? 0 : int'(vw)),
					near_wall($urandom_range(1) ? int'(vt) : int'(vh)),
					near_wall($urandom_range(1) ? 0 : int'(vw)),
					near_wall($urandom_range(1) ? int'(vt) : int'(vh)));
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk) arst_n = 1;
		// directed: crossings on each wall, corners, endpoints, parallels, extremes
		send(-10, 400, 10, 400);
		send(500, 0, 500, 200);
		send(1270, 400, 1290, 400);
		send(500, 800, 500, 900);
		send(-10, 100, 10, 100);
		send(0, 400, 10, 400);
		send(-10, 400, 0, 400);
		send(0, 50, 0, 900);
		send(100, 100, 900, 100);
		send(400, 400, 500, 500);
		send(-8192, -8192, 8191, 8191);
		send(8191, -8192, -8192, 8191);
		send(-8192, 8191, 8191, -8192);
		send(5, 5, 5, 5);
		send(-1, 99, 1, 101);
		send(-3, 401, 4, 405);
		send(-1, -1, -1, -1);
		set_view(4095, 4095, 0);
		send(-8192, 2000, 8191, 2000);
		send(2000, -8192, 2000, 8191);
		set_view(1, 1, 4095);
		send(-5, 0, 5, 3);
		send(0, -5, 0, 5000);
		send(-8192, 2, 8191, 2);
		set_view(svwi_pkg::VIEW_WIDTH_RST, svwi_pkg::VIEW_HEIGHT_RST, svwi_pkg::VIEW_TOP_RST);
		random_segments(100);
		send_idle = 65;
		random_segments(80);
		send_idle = 0; recv_stall = 65;
		random_segments(80);
		send_idle = 19; recv_stall = 19;
		set_view(64, 48, 8);
		random_segments(80);
		drain();
		send_idle = 0; recv_stall = 0;
		fork
			begin
				hold_off = 1;
				repeat (200) @(posedge clk);
				hold_off = 0;
			end
			random_segments(60);
		join
		drain();
		set_view(300, 20, 200);
		random_segments(50);
		set_view(CFW'($urandom_range(1, 4095)), CFW'($urandom_range(1, 4095)),
			CFW'($urandom_range(4095)));
		random_segments(50);
		drain();
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule
